FILE: src/spcm_pkg.sv
// Shared types, constants and command codes of the stereo PCM channel mixer.
`default_nettype none
package spcm_pkg;

   // Table and frame store sizes.
   localparam int CHANNELS   = 8;
   localparam int MAX_FRAMES = 1024;
   localparam int CHAN_W     = $clog2(CHANNELS);
   localparam int FRAME_W    = $clog2(MAX_FRAMES);
   localparam int LIMIT_W    = 11;
   localparam int LEN_W      = 24;

   // Command codes.
   localparam logic [2:0] CMD_PLAY   = 3'd0;
   localparam logic [2:0] CMD_STOP   = 3'd1;
   localparam logic [2:0] CMD_VOLUME = 3'd2;
   localparam logic [2:0] CMD_QUERY  = 3'd3;
   localparam logic [2:0] CMD_PASS   = 3'd4;
   localparam logic [2:0] CMD_MIX    = 3'd5;
   localparam logic [2:0] CMD_READ   = 3'd6;

   // Status codes.
   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_REJECT  = 2'd1;
   localparam logic [1:0] STAT_IGNORED = 2'd2;

   // Frame limit after reset.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd256;

   // Request transaction.
   typedef struct packed {
      logic [2:0]         command;
      logic [2:0]         channel;
      logic               auto_pick;
      logic [23:0]        sound_length;
      logic [7:0]         gain_left;
      logic [7:0]         gain_right;
      logic signed [15:0] sample;
      logic [9:0]         frame;
   } req_type;

   // Response transaction.
   typedef struct packed {
      logic [1:0]         status;
      logic [2:0]         channel_used;
      logic               playing;
      logic signed [15:0] left;
      logic signed [15:0] right;
   } rsp_type;

endpackage
`default_nettype wire

FILE: src/stereo_pcm_channel_mixer.sv
// Stereo PCM channel mixer: channel table, frame store and command sequencer.
// A result is strobed from a register loaded in the execute step, or for a mix sample
// in the write back step that follows it. A command is taken only when not busy;
// busy covers the frame store read, the gain multiply and the write back.
// Reset: synchronous; afterwards the frame store is cleared one frame a cycle
// with busy high. The receiver cannot stall results.
`default_nettype none
module stereo_pcm_channel_mixer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire spcm_pkg::req_type            req_payload,
   output logic                              rsp_strobe,
   output spcm_pkg::rsp_type                 rsp_payload,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [spcm_pkg::LIMIT_W-1:0] csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;

   // Sequencer and request registers.
   logic [2:0]                          state_ff, state_in;
   logic [spcm_pkg::FRAME_W-1:0]        clr_cnt_ff, clr_cnt_in;
   spcm_pkg::req_type                   req_ff;
   logic [spcm_pkg::FRAME_W-1:0]        addr_ff;
   logic [spcm_pkg::LIMIT_W-1:0]        limit_cfg_ff;
   logic signed [23:0]                  prod_l_ff, prod_r_ff;
   logic signed [23:0]                  prod_l_in, prod_r_in;
   logic                                rsp_strobe_ff, rsp_strobe_in;
   spcm_pkg::rsp_type                   rsp_ff, rsp_in;

   // Channel table.
   logic [spcm_pkg::LEN_W-1:0]   len_ff [spcm_pkg::CHANNELS];
   logic [spcm_pkg::LEN_W-1:0]   len_in [spcm_pkg::CHANNELS];
   logic [spcm_pkg::LEN_W-1:0]   pos_ff [spcm_pkg::CHANNELS];
   logic [spcm_pkg::LEN_W-1:0]   pos_in [spcm_pkg::CHANNELS];
   logic [spcm_pkg::LIMIT_W-1:0] pc_ff  [spcm_pkg::CHANNELS];
   logic [spcm_pkg::LIMIT_W-1:0] pc_in  [spcm_pkg::CHANNELS];
   logic [7:0]                   gl_ff  [spcm_pkg::CHANNELS];
   logic [7:0]                   gl_in  [spcm_pkg::CHANNELS];
   logic [7:0]                   gr_ff  [spcm_pkg::CHANNELS];
   logic [7:0]                   gr_in  [spcm_pkg::CHANNELS];
   logic [spcm_pkg::CHANNELS-1:0] act_ff, act_in;

   // Frame store.
   logic [31:0]                  frame_mem [spcm_pkg::MAX_FRAMES];
   logic [31:0]                  rd_ff;
   logic                         mem_we, mem_re;
   logic [spcm_pkg::FRAME_W-1:0] mem_wa, mem_ra;
   logic [31:0]                  mem_wd;

   logic                         accept;
   logic [spcm_pkg::CHAN_W-1:0]  ch;
   logic [spcm_pkg::CHAN_W-1:0]  pick;
   logic [spcm_pkg::CHAN_W-1:0]  used;
   logic [spcm_pkg::LIMIT_W-1:0] limit;
   logic signed [24:0]           mul_l, mul_r;
   logic signed [15:0]           sc_l, sc_r, new_l, new_r;
   logic signed [16:0]           sum_l, sum_r;
   logic [spcm_pkg::LEN_W-1:0]   pos_next;

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;
   assign ch         = req_ff.channel;

   // Effective frame limit, capped at the store depth.
   assign limit = (limit_cfg_ff > spcm_pkg::LIMIT_W'(spcm_pkg::MAX_FRAMES))
                ? spcm_pkg::LIMIT_W'(spcm_pkg::MAX_FRAMES) : limit_cfg_ff;

   // First idle channel, channel 0 when all are playing.
   always_comb begin
      pick = '0;
      for (int i = spcm_pkg::CHANNELS - 1; i >= 0; i--) begin
         if (!act_ff[i]) pick = spcm_pkg::CHAN_W'(i);
      end
   end

   // Gain products; the sample times an 8-bit gain fits in 24 bits.
   assign mul_l = $signed(req_ff.sample) * $signed({1'b0, gl_ff[ch]});
   assign mul_r = $signed(req_ff.sample) * $signed({1'b0, gr_ff[ch]});

   // Arithmetic shift by 8 and saturating accumulate into the frame pair.
   always_comb begin
      sc_l  = prod_l_ff[23:8];
      sc_r  = prod_r_ff[23:8];
      sum_l = {rd_ff[15], rd_ff[15:0]} + {sc_l[15], sc_l};
      sum_r = {rd_ff[31], rd_ff[31:16]} + {sc_r[15], sc_r};
      new_l = (sum_l[16] != sum_l[15]) ? (sum_l[16] ? 16'sh8000 : 16'sh7fff) : sum_l[15:0];
      new_r = (sum_r[16] != sum_r[15]) ? (sum_r[16] ? 16'sh8000 : 16'sh7fff) : sum_r[15:0];
   end

   assign pos_next = pos_ff[ch] + 24'd1;

   // Sequencer, channel table updates and response.
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      pc_in         = pc_ff;
      gl_in         = gl_ff;
      gr_in         = gr_ff;
      act_in        = act_ff;
      prod_l_in     = prod_l_ff;
      prod_r_in     = prod_r_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      used          = ch;
      mem_we        = 1'b0;
      mem_wa        = addr_ff;
      mem_wd        = 32'd0;
      mem_re        = accept;
      mem_ra        = (req_payload.command == spcm_pkg::CMD_READ)
                    ? req_payload.frame
                    : pc_ff[req_payload.channel][spcm_pkg::FRAME_W-1:0];

      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == spcm_pkg::FRAME_W'(spcm_pkg::MAX_FRAMES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            rsp_in.status = spcm_pkg::STAT_DONE;
            rsp_in.left   = 16'sd0;
            rsp_in.right  = 16'sd0;
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            case (req_ff.command)
               spcm_pkg::CMD_PLAY: begin
                  if (req_ff.sound_length == 24'd0) begin
                     rsp_in.status = spcm_pkg::STAT_REJECT;
                  end else begin
                     if (req_ff.auto_pick) used = pick;
                     len_in[used] = req_ff.sound_length;
                     pos_in[used] = 24'd0;
                     pc_in[used]  = '0;
                     gl_in[used]  = req_ff.gain_left;
                     gr_in[used]  = req_ff.gain_right;
                     act_in[used] = 1'b1;
                  end
               end
               spcm_pkg::CMD_STOP: begin
                  act_in[ch] = 1'b0;
               end
               spcm_pkg::CMD_VOLUME: begin
                  gl_in[ch] = req_ff.gain_left;
                  gr_in[ch] = req_ff.gain_right;
               end
               spcm_pkg::CMD_PASS: begin
                  for (int i = 0; i < spcm_pkg::CHANNELS; i++) pc_in[i] = '0;
               end
               spcm_pkg::CMD_MIX: begin
                  if (!act_ff[ch] || pc_ff[ch] >= limit) begin
                     rsp_in.status = spcm_pkg::STAT_IGNORED;
                  end else begin
                     // Register the products; accumulate in the next cycle.
                     prod_l_in     = mul_l[23:0];
                     prod_r_in     = mul_r[23:0];
                     state_in      = ST_WRITE;
                     rsp_strobe_in = 1'b0;
                  end
               end
               spcm_pkg::CMD_READ: begin
                  rsp_in.left  = rd_ff[15:0];
                  rsp_in.right = rd_ff[31:16];
                  mem_we       = 1'b1;
               end
               default: begin
               end
            endcase
            rsp_in.channel_used = used;
            rsp_in.playing      = act_in[used];
         end
         ST_WRITE: begin
            mem_we     = 1'b1;
            mem_wd     = {new_r, new_l};
            pc_in[ch]  = pc_ff[ch] + 1'b1;
            pos_in[ch] = pos_next;
            if (pos_next >= len_ff[ch]) act_in[ch] = 1'b0;
            rsp_in.channel_used = ch;
            rsp_in.playing      = act_in[ch];
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
         limit_cfg_ff  <= spcm_pkg::LIMIT_RESET;
         act_ff        <= '0;
         for (int i = 0; i < spcm_pkg::CHANNELS; i++) begin
            len_ff[i] <= '0;
            pos_ff[i] <= '0;
            pc_ff[i]  <= '0;
            gl_ff[i]  <= '0;
            gr_ff[i]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
         act_ff        <= act_in;
         len_ff        <= len_in;
         pos_ff        <= pos_in;
         pc_ff         <= pc_in;
         gl_ff         <= gl_in;
         gr_ff         <= gr_in;
         if (csr_valid && csr_ready) limit_cfg_ff <= csr_data;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      prod_l_ff <= prod_l_in;
      prod_r_ff <= prod_r_in;
      rsp_ff    <= rsp_in;
      if (accept) begin
         req_ff  <= req_payload;
         addr_ff <= mem_ra;
      end
   end

   // Frame store with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) frame_mem[mem_wa] <= mem_wd;
      if (mem_re) rd_ff <= frame_mem[mem_ra];
   end

   // A result only follows an execute or write back step.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_EXEC || $past(state_ff) == ST_WRITE)
      else $error("response without a finishing step");

   // An accepted transaction makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted transaction did not start");

   // The write back step only follows the multiply step of a mix.
   a_write_after_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> $past(state_ff) == ST_EXEC && req_ff.command == spcm_pkg::CMD_MIX)
      else $error("write back outside a mix");

   // No response while the frame store is being cleared.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_strobe)
      else $error("response during clearing");

endmodule
`default_nettype wire
